### design/pci_config_access_mechanism_unit_macros.svh
// Assertion macros shared by the configuration access unit.
`ifndef PCI_CONFIG_ACCESS_MECHANISM_UNIT_MACROS_SVH
`define PCI_CONFIG_ACCESS_MECHANISM_UNIT_MACROS_SVH
`ifndef SYNTH
`define PCAM_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("pcam assertion failed");
`define PCAM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcam implication failed");
`else
`define PCAM_ASSERT(label, expr)
`define PCAM_ASSERT_IMP(label, ante, cons)
`endif
`endif

### design/pcam_pkg.sv
// Types and constants of the configuration access unit.
package pcam_pkg;

  localparam int NUM_SLOTS     = 4;
  localparam int CONFIG_BYTES  = 256;
  localparam int LANES         = 4;
  localparam int ROWS_PER_SLOT = CONFIG_BYTES / LANES;
  localparam int RAM_DEPTH     = NUM_SLOTS * ROWS_PER_SLOT;
  localparam int RAM_AW        = $clog2(RAM_DEPTH);
  localparam int ROW_W         = $clog2(ROWS_PER_SLOT);
  localparam int SLOT_W        = 2;
  localparam int CNT_W         = 3;
  localparam int ID_W          = 16;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CNT_W-1:0] MAX_ACCESS = 3'd4;
  localparam int ENABLE_BIT = 31;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT0_ID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT1_ID   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT2_ID   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT3_ID   = 3'd4;

  typedef struct packed {
    logic        op;
    logic [2:0]  port_offset;
    logic [2:0]  access_size;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [3:0]  notify_mask;
    logic [1:0]  notify_slot;
    logic [7:0]  notify_offset;
    logic [31:0] notify_data;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic exec;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

### design/pcam_ram.sv
// Generic single-port RAM with registered read.
module pcam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### design/pcam_ctrl.sv
// Controller state machine of the configuration access unit.
module pcam_ctrl
  import pcam_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output logic busy,
  output cmd_t cmd
);

`include "pci_config_access_mechanism_unit_macros.svh"

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_RESP;
      ST_RESP:  state_nxt = start ? ST_EXEC : ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // A new transfer may be taken in the cycle that shows the previous result.
  always_comb begin
    busy        = 1'b1;
    cmd.clear   = 1'b0;
    cmd.exec    = 1'b0;
    cmd.resp    = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE:  busy = 1'b0;
      ST_EXEC:  cmd.exec = 1'b1;
      ST_RESP: begin
        busy     = 1'b0;
        cmd.resp = 1'b1;
      end
      default: cmd.clear = 1'b1;
    endcase
    cmd.capture = start && !busy;
  end

  `PCAM_ASSERT(a_resp_not_busy, !(busy && cmd.resp))
  `PCAM_ASSERT_IMP(a_exec_then_resp, cmd.exec, ##1 cmd.resp)
  `PCAM_ASSERT_IMP(a_capture_then_exec, cmd.capture, ##1 cmd.exec)

endmodule

### design/pcam_dp.sv
// Datapath: address register, slot match, byte-lane config store and result.
module pcam_dp
  import pcam_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]      cfg_wdata,
  input  in_item_t             in_item,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output out_item_t            out_item
);

`include "pci_config_access_mechanism_unit_macros.svh"

  in_item_t          item_r;
  logic [31:0]       cfg_addr_r, cfg_addr_nxt;
  logic [CNT_W-1:0]  slot_count_r;
  logic [ID_W-1:0]   slot_id_r [NUM_SLOTS];
  logic [RAM_AW-1:0] clr_cnt_r;
  logic              sel_hit_r;
  logic [SLOT_W-1:0] sel_slot_r;

  logic [CNT_W-1:0]  size_c;
  logic [CNT_W-1:0]  nslots_c;
  logic              win_c;
  logic [7:0]        base_c;
  logic              hit_c;
  logic [SLOT_W-1:0] slot_c;
  logic              lane_we   [LANES];
  logic [RAM_AW-1:0] lane_addr [LANES];
  logic [7:0]        lane_wd   [LANES];
  logic [7:0]        lane_q    [LANES];

  // Item register and slot configuration.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.exec) begin
      sel_hit_r  <= hit_c;
      sel_slot_r <= slot_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_addr_r   <= '0;
      slot_count_r <= '0;
      clr_cnt_r    <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_id_r[s] <= '0;
      end
    end else begin
      cfg_addr_r <= cfg_addr_nxt;
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_SLOT_COUNT: slot_count_r <= cfg_wdata[CNT_W-1:0];
          REG_SLOT0_ID:   slot_id_r[0] <= cfg_wdata;
          REG_SLOT1_ID:   slot_id_r[1] <= cfg_wdata;
          REG_SLOT2_ID:   slot_id_r[2] <= cfg_wdata;
          REG_SLOT3_ID:   slot_id_r[3] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign sts.clear_last = (clr_cnt_r == RAM_AW'(RAM_DEPTH - 1));

  assign size_c   = (item_r.access_size > MAX_ACCESS) ? MAX_ACCESS : item_r.access_size;
  assign nslots_c = (slot_count_r > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : slot_count_r;
  // Offsets four and up form the data window.
  assign win_c    = item_r.port_offset[2];
  assign base_c   = {cfg_addr_r[7:2], item_r.port_offset[1:0]};

  // Bus, device and function sit in bits 23:8 in the same layout as a slot id.
  always_comb begin
    hit_c  = 1'b0;
    slot_c = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (nslots_c > CNT_W'(s) && slot_id_r[s] == cfg_addr_r[23:8]) begin
        hit_c  = 1'b1;
        slot_c = SLOT_W'(s);
      end
    end
    hit_c = hit_c && cfg_addr_r[ENABLE_BIT];
  end

  // Address register bytes, written only inside the access.
  always_comb begin
    logic [1:0] i;
    cfg_addr_nxt = cfg_addr_r;
    i = '0;
    if (cmd.exec && !win_c && item_r.op == OP_WRITE) begin
      for (int p = 0; p < 4; p++) begin
        i = 2'(p) - item_r.port_offset[1:0];
        if (2'(p) >= item_r.port_offset[1:0] && {1'b0, i} < size_c) begin
          cfg_addr_nxt[8*p +: 8] = item_r.write_data[{i, 3'b000} +: 8];
        end
      end
    end
  end

  // Byte lane l holds config offsets with low bits l; an access of up to four
  // consecutive bytes touches each lane at most once.
  always_comb begin
    logic [1:0]       k;
    logic [ROW_W-1:0] row;
    k   = '0;
    row = '0;
    for (int l = 0; l < LANES; l++) begin
      k   = 2'(l) - base_c[1:0];
      row = (2'(l) >= base_c[1:0]) ? base_c[7:2] : base_c[7:2] + 1'b1;
      if (cmd.clear) begin
        lane_we[l]   = 1'b1;
        lane_addr[l] = clr_cnt_r;
        lane_wd[l]   = '0;
      end else begin
        lane_we[l]   = cmd.exec && win_c && item_r.op == OP_WRITE && hit_c &&
                       ({1'b0, k} < size_c);
        lane_addr[l] = {slot_c, row};
        lane_wd[l]   = item_r.write_data[{k, 3'b000} +: 8];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    pcam_ram #(
      .WIDTH(8),
      .DEPTH(RAM_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (lane_we[l]),
      .addr (lane_addr[l]),
      .wdata(lane_wd[l]),
      .rdata(lane_q[l])
    );
  end

  // Result, formed in the cycle after the store was read.
  always_comb begin
    logic [1:0] lane;
    logic [2:0] pos;
    logic       take;
    lane     = '0;
    pos      = '0;
    take     = 1'b0;
    out_item = '0;
    for (int i = 0; i < 4; i++) begin
      take = ({1'b0, 2'(i)} < size_c);
      lane = base_c[1:0] + 2'(i);
      pos  = item_r.port_offset + 3'(i);
      if (take && item_r.op == OP_READ) begin
        if (win_c) begin
          out_item.read_data[8*i +: 8] = sel_hit_r ? lane_q[lane] : 8'hff;
        end else if (pos < 3'd4) begin
          out_item.read_data[8*i +: 8] = cfg_addr_r[{pos[1:0], 3'b000} +: 8];
        end
      end
      if (take && item_r.op == OP_WRITE && win_c && sel_hit_r) begin
        out_item.notify_mask[i]        = 1'b1;
        out_item.notify_data[8*i +: 8] = item_r.write_data[8*i +: 8];
      end
    end
    if (item_r.op == OP_WRITE && win_c && sel_hit_r && size_c != '0) begin
      out_item.notify_slot   = sel_slot_r;
      out_item.notify_offset = base_c;
    end
  end

  `PCAM_ASSERT_IMP(a_hit_needs_enable, hit_c, cfg_addr_r[ENABLE_BIT])
  `PCAM_ASSERT_IMP(a_store_write_needs_hit,
                   cmd.exec && (lane_we[0] || lane_we[1] || lane_we[2] || lane_we[3]),
                   hit_c && win_c)
  `PCAM_ASSERT_IMP(a_clear_wraps, cmd.clear && sts.clear_last, ##1 clr_cnt_r == '0)

endmodule

### design/pci_config_access_mechanism_unit.sv
// A transfer taken on start passes through the exec state, which reads the byte-lane
// config store RAMs through their registered read, and has its result strobed in the
// result state; start is taken again in the result state.
// Reset (rst_n low, synchronous) zeroes the address and slot registers, then
// busy stays high while the config store is cleared.
module pci_config_access_mechanism_unit
  import pcam_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_strobe,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]      cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // Register writes are never stalled: cfg_ready is tied high.
  assign cfg_ready  = 1'b1;
  assign out_strobe = cmd.resp;

  pcam_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .busy (busy),
    .cmd  (cmd)
  );

  pcam_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule
